// ----- rtl/ordered_dither_pack_1bpp_macros.svh -----
// Assertion macros for the ordered dither packer.
// Used by ordered_dither_pack_1bpp.sv; expects clk and rst_n in scope.
`ifndef ORDERED_DITHER_PACK_1BPP_MACROS_SVH
`define ORDERED_DITHER_PACK_1BPP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset
`define ODP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset
`define ODP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ODP_ASSERT_IMP(lbl, ante, cons)
`define ODP_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/odp1_pkg.sv -----
// Package for the ordered dither packer: Bayer threshold table and register indexes.
// No dependencies.
package odp1_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_MATRIX_MODE  = 2'd2
  } cfg_reg_t;

  localparam logic [15:0] RST_IMAGE_WIDTH  = 16'd512;
  localparam logic [15:0] RST_IMAGE_HEIGHT = 16'd1;
  localparam logic        RST_MATRIX_MODE  = 1'b1;

  typedef logic [7:0] bayer_row_t [8];

  // 8x8 Bayer thresholds; the top-left quarter is the 4x4 matrix
  localparam bayer_row_t BAYER_8X8 [8] = '{
    '{8'd0,   8'd128, 8'd32,  8'd160, 8'd8,   8'd136, 8'd40,  8'd168},
    '{8'd192, 8'd64,  8'd224, 8'd96,  8'd200, 8'd72,  8'd232, 8'd104},
    '{8'd48,  8'd176, 8'd16,  8'd144, 8'd56,  8'd184, 8'd24,  8'd152},
    '{8'd240, 8'd112, 8'd208, 8'd80,  8'd248, 8'd120, 8'd216, 8'd88},
    '{8'd12,  8'd140, 8'd44,  8'd172, 8'd4,   8'd132, 8'd36,  8'd164},
    '{8'd204, 8'd76,  8'd236, 8'd108, 8'd196, 8'd68,  8'd228, 8'd100},
    '{8'd60,  8'd188, 8'd28,  8'd156, 8'd52,  8'd180, 8'd20,  8'd148},
    '{8'd252, 8'd124, 8'd220, 8'd92,  8'd244, 8'd116, 8'd212, 8'd84}
  };

  function automatic logic [7:0] bayer_threshold(input logic [2:0] row,
                                                 input logic [2:0] col);
    bayer_threshold = BAYER_8X8[row][col];
  endfunction

endpackage

// ----- rtl/ordered_dither_pack_1bpp.sv -----
// Ordered (Bayer) dither with 1-bit-per-pixel packing, top level.
// Depends on odp1_pkg and ordered_dither_pack_1bpp_macros.svh.
//
// Usage:
//   Grey pixels (8 bits) arrive in raster order on the in_ stream. Each is
//   compared against a Bayer threshold picked by row and column (8x8 table,
//   or its 4x4 top-left quarter). Dots are packed MSB-first, eight to a byte,
//   and a byte is sent on the out_ stream when full or when a row ends (the
//   partial byte padded with zeros). out_tlast marks the end of a row,
//   out_tuser the end of the last row of the image.
//   A pixel that closes a byte shows its byte in the cycle after its
//   transfer. Throughput: one pixel per cycle, set by the single output
//   register; in_tready drops only while that register holds a byte the
//   receiver has not taken. When the receiver stalls, the byte is held.
//   Reset clears the column, row and packing state and loads the register
//   defaults: width 512, height 1, 8x8 matrix. Write cfg_ only while idle.
`include "ordered_dither_pack_1bpp_macros.svh"

module ordered_dither_pack_1bpp (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // Pixel input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] grey_level
  // Packed byte output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] packed_byte
  output logic        out_tlast,  // row_last
  output logic        out_tuser   // [0] image_last
);

  import odp1_pkg::*;

  // Configuration registers
  logic [15:0] width_r;
  logic [15:0] height_r;
  logic        mode_r;

  // Scan and packing state
  logic [15:0] col_r, col_nxt;
  logic [15:0] row_r, row_nxt;
  logic [7:0]  acc_r, acc_nxt;
  logic [2:0]  pos_r, pos_nxt;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r;
  logic        out_row_last_r;
  logic        out_img_last_r;

  logic        in_xfer;
  logic        out_xfer;
  logic [15:0] last_col;
  logic [15:0] last_row;
  logic        row_end;
  logic        image_end;
  logic        byte_full;
  logic        emit;
  logic [2:0]  tbl_row;
  logic [2:0]  tbl_col;
  logic [7:0]  threshold;
  logic        dot;
  logic [7:0]  acc_with_dot;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_valid_r && out_tready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_IMAGE_WIDTH;
      height_r <= RST_IMAGE_HEIGHT;
      mode_r   <= RST_MATRIX_MODE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        REG_MATRIX_MODE:  mode_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Row and image end; a zero register acts as 65536
  assign last_col  = width_r - 16'd1;
  assign last_row  = height_r - 16'd1;
  assign row_end   = col_r >= last_col;
  assign image_end = row_end && (row_r >= last_row);
  assign byte_full = pos_r == 3'd7;
  assign emit      = byte_full || row_end;

  // Threshold lookup and dot decision
  assign tbl_row      = mode_r ? row_r[2:0] : {1'b0, row_r[1:0]};
  assign tbl_col      = mode_r ? col_r[2:0] : {1'b0, col_r[1:0]};
  assign threshold    = bayer_threshold(tbl_row, tbl_col);
  assign dot          = in_tdata <= threshold;
  assign acc_with_dot = dot ? (acc_r | (8'h80 >> pos_r)) : acc_r;

  // Next state for one pixel transfer and for the output handshake
  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    acc_nxt       = acc_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_xfer;
    if (in_xfer) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = image_end ? '0 : row_r + 16'd1;
      end else begin
        col_nxt = col_r + 16'd1;
      end
      if (emit) begin
        acc_nxt       = '0;
        pos_nxt       = '0;
        out_valid_nxt = 1'b1;
      end else begin
        acc_nxt = acc_with_dot;
        pos_nxt = pos_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      acc_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      acc_r       <= acc_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload, loaded when a byte is emitted
  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      out_byte_r     <= acc_with_dot;
      out_row_last_r <= row_end;
      out_img_last_r <= image_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_row_last_r;
  assign out_tuser  = out_img_last_r;

  // Checks
  `ODP_ASSERT_IMP(a_img_end_is_row_end, out_valid_r && out_img_last_r, out_row_last_r)
  `ODP_ASSERT_NXT(a_emit_clears_pack, in_xfer && emit, acc_r == 8'd0 && pos_r == 3'd0)
  `ODP_ASSERT_NXT(a_row_end_clears_col, in_xfer && row_end, col_r == 16'd0)
  `ODP_ASSERT_IMP(a_ready_when_empty, !out_valid_r, in_tready)

endmodule
